[hdl/p3d_pkg.sv]
package p3d_pkg;

	localparam int SAMPLE_BITS = 16;
	localparam int ACC_BITS    = SAMPLE_BITS + 6;
	localparam int EXTENT_BITS = 10;
	localparam int ADDR_BITS   = 12;
	localparam int OUT_POSITIONS = 1 << ADDR_BITS;
	localparam int MAX_WINDOW  = 4;
	localparam int CFG_IDX_BITS = 3;
	localparam int CFG_DATA_BITS = 30;
	localparam int COUNT_BITS  = 7;

	localparam logic [CFG_IDX_BITS-1:0] REG_POOL_MODE  = 3'd0;
	localparam logic [CFG_IDX_BITS-1:0] REG_IN_EXTENTS = 3'd1;
	localparam logic [CFG_IDX_BITS-1:0] REG_OUT_EXTENTS = 3'd2;
	localparam logic [CFG_IDX_BITS-1:0] REG_WINDOWS    = 3'd3;
	localparam logic [CFG_IDX_BITS-1:0] REG_STRIDES    = 3'd4;
	localparam logic [CFG_IDX_BITS-1:0] REG_PADS       = 3'd5;

	localparam logic [29:0] EXTENTS_RESET = 30'd1049601;
	localparam logic [8:0]  WINDOWS_RESET = 9'd73;
	localparam logic [11:0] STRIDES_RESET = 12'd273;

	localparam logic MODE_MAX = 1'b0;
	localparam logic MODE_AVG = 1'b1;

	// Windows covering one coordinate on one axis, indexed by the offset j
	// below the highest candidate window (window index q - j).
	typedef struct packed {
		logic                        any;
		logic [1:0]                  jmax;
		logic [1:0]                  jmin;
		logic [1:0]                  jl;
		logic [EXTENT_BITS-1:0]      plo;
		logic [MAX_WINDOW-1:0]       first;
		logic [MAX_WINDOW-1:0]       last;
		logic [MAX_WINDOW-1:0]       endpos;
		logic [MAX_WINDOW-1:0][2:0]  len;
	} p3d_hit_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_DIV,
		ST_HITS,
		ST_MUL1,
		ST_MUL2,
		ST_RD,
		ST_WR,
		ST_AVG,
		ST_OUT,
		ST_ADV
	} p3d_state_t;

endpackage

[hdl/p3d_div.sv]
module p3d_div
	#(
	parameter int DW   = 11,
	parameter int VW   = 4,
	parameter int STEP = 4
	)
	(
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [DW-1:0] dividend,
	input  logic [VW-1:0] divisor,
	output logic          busy,
	output logic [DW-1:0] quotient,
	output logic [VW-1:0] remainder
	);

	localparam int NSTEP = (DW + STEP - 1) / STEP;
	localparam int PW    = NSTEP * STEP;
	localparam int CW    = $clog2(NSTEP + 1);

	logic [VW-1:0] rem_q, rem_n;
	logic [PW-1:0] quo_q, quo_n;
	logic [VW-1:0] dvs_q;
	logic [CW-1:0] cnt_q;
	logic          busy_q;

	// Restoring division, STEP quotient bits per cycle.
	always_comb begin
		logic [VW:0] part;
		rem_n = rem_q;
		quo_n = quo_q;
		for (int i = 0; i < STEP; i++) begin
			part  = {rem_n, quo_n[PW-1]};
			quo_n = {quo_n[PW-2:0], 1'b0};
			if (part >= {1'b0, dvs_q}) begin
				part     = part - {1'b0, dvs_q};
				quo_n[0] = 1'b1;
			end
			rem_n = part[VW-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= CW'(NSTEP);
		end else if (busy_q) begin
			cnt_q  <= cnt_q - 1'b1;
			busy_q <= (cnt_q != CW'(1));
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= PW'(dividend);
			dvs_q <= divisor;
		end else if (busy_q) begin
			rem_q <= rem_n;
			quo_q <= quo_n;
		end
	end

	assign busy      = busy_q;
	assign quotient  = quo_q[DW-1:0];
	assign remainder = rem_q;

endmodule

[hdl/p3d_axis.sv]
module p3d_axis
	import p3d_pkg::*;
	(
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   start,
	input  logic [EXTENT_BITS-1:0] coord,
	input  logic [EXTENT_BITS-1:0] in_ext,
	input  logic [EXTENT_BITS-1:0] out_ext,
	input  logic [2:0]             win,
	input  logic [3:0]             stride,
	input  logic [1:0]             pad,
	output logic                   busy,
	output p3d_hit_t               hit
	);

	localparam int QW = EXTENT_BITS + 1;
	localparam int SW = EXTENT_BITS + 3;

	logic [EXTENT_BITS-1:0] x_q;
	logic [2:0]             k_eff;
	logic [3:0]             s_eff;
	logic [QW-1:0]          q;
	logic [3:0]             r;

	assign k_eff = (win > 3'(MAX_WINDOW)) ? 3'(MAX_WINDOW) : win;
	assign s_eff = (stride == 4'd0) ? 4'd1 : stride;

	always_ff @(posedge clk) begin
		if (start) begin
			x_q <= coord;
		end
	end

	p3d_div #(.DW(QW), .VW(4), .STEP(4)) u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.dividend  (QW'(coord) + QW'(pad)),
		.divisor   (s_eff),
		.busy      (busy),
		.quotient  (q),
		.remainder (r)
	);

	// Window q - j covers x when its start x - r - j*s is within k - 1 below x.
	always_comb begin
		logic                  valid;
		logic [MAX_WINDOW-1:0] cov;
		logic [5:0]            js;
		logic signed [SW-1:0]  st, cs, en;
		valid = (x_q < in_ext) && (k_eff != 3'd0) && (out_ext != '0);
		hit   = '0;
		cov   = '0;
		for (int j = 0; j < MAX_WINDOW; j++) begin
			js = 6'(s_eff) * 6'(j);
			cov[j] = valid && ((7'(js) + 7'(r)) <= 7'(k_eff - 3'd1))
				&& (QW'(j) <= q) && ((q - QW'(j)) <= (QW'(out_ext) - QW'(1)));
			st = SW'(x_q) - SW'(r) - SW'(js);
			cs = st[SW-1] ? '0 : st;
			en = st + SW'(k_eff);
			if (en > SW'(in_ext)) begin
				en = SW'(in_ext);
			end
			hit.first[j]  = (SW'(x_q) == cs);
			hit.last[j]   = (SW'(x_q) == en - SW'(1));
			hit.len[j]    = 3'(en - cs);
			hit.endpos[j] = ((q - QW'(j)) == (QW'(out_ext) - QW'(1)));
		end
		hit.any = |cov;
		for (int j = 0; j < MAX_WINDOW; j++) begin
			if (cov[j]) begin
				hit.jmax = 2'(j);
			end
		end
		for (int j = MAX_WINDOW - 1; j >= 0; j--) begin
			if (cov[j]) begin
				hit.jmin = 2'(j);
			end
			if (cov[j] && hit.last[j]) begin
				hit.jl = 2'(j);
			end
		end
		hit.plo = EXTENT_BITS'(q - QW'(hit.jmax));
	end

endmodule

[hdl/p3d_accmem.sv]
module p3d_accmem
	import p3d_pkg::*;
	(
	input  logic                 clk,
	input  logic                 wr_en,
	input  logic [ADDR_BITS-1:0] wr_addr,
	input  logic [ACC_BITS-1:0]  wr_data,
	input  logic                 rd_en,
	input  logic [ADDR_BITS-1:0] rd_addr,
	output logic [ACC_BITS-1:0]  rd_data
	);

	logic [ACC_BITS-1:0] mem [OUT_POSITIONS];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

[hdl/pool3d_forward_max_avg.sv]
// Sequence: coordinate division and setup, then a read, a write and an advance step per
// covering window, an output step per finished window and its divide in average mode.
// Throughput: one item at a time; the next sample waits for the walk over up to 64
// covering windows and for result stalls, set by the accumulator read-modify-write.
// Reset: asynchronous, active low; registers return to their defaults and the raster
// counters to zero. Accumulators are not cleared.
module pool3d_forward_max_avg
	import p3d_pkg::*;
	(
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     sample_valid,
	output logic                     sample_stall,
	input  logic signed [SAMPLE_BITS-1:0] sample,
	output logic                     result_valid,
	input  logic                     result_stall,
	output logic signed [SAMPLE_BITS-1:0] pooled_value,
	output logic [ADDR_BITS-1:0]     out_position,
	output logic                     last_in_run,
	output logic                     last_of_volume,
	input  logic                     cfg_valid,
	output logic                     cfg_ready,
	input  logic [CFG_IDX_BITS-1:0]  cfg_index,
	input  logic [CFG_DATA_BITS-1:0] cfg_data
	);

	localparam int EB = EXTENT_BITS;

	// Configuration registers.
	logic        mode_q;
	logic [29:0] in_ext_q;
	logic [29:0] out_ext_q;
	logic [8:0]  win_q;
	logic [11:0] stride_q;
	logic [5:0]  pad_q;

	// Raster position of the next sample.
	logic [EB-1:0] col_q, row_q, dep_q;

	p3d_state_t state_q, state_n;

	logic accept;
	logic axis_start;
	logic div_busy;
	logic bw, bh, bd;
	p3d_hit_t hw_c, hh_c, hd_c;
	p3d_hit_t hw_q, hh_q, hd_q;

	logic signed [SAMPLE_BITS-1:0] smp_q;
	logic [1:0]           jw_q, jh_q, jd_q;
	logic [EB-1:0]        pw_q;
	logic [ADDR_BITS-1:0] plane_q, hterm0_q, hterm_q, dterm_q;
	logic [ADDR_BITS-1:0] addr;
	logic [ACC_BITS-1:0]  rd_data;
	logic signed [ACC_BITS-1:0] acc_old, acc_new, acc_q;
	logic                 first_all, last_all;
	logic                 lir_q, lov_q, neg_q;
	logic                 avg_start;
	logic [ACC_BITS-1:0]  avg_mag;
	logic [ACC_BITS-1:0]  avg_quo;
	logic [COUNT_BITS-1:0] avg_cnt;
	logic [COUNT_BITS-1:0] avg_rem;
	logic                 avg_busy;
	logic                 out_load;
	logic                 mem_rd, mem_wr;
	logic                 adv_done;
	logic signed [SAMPLE_BITS-1:0] res_value;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q    <= MODE_MAX;
			in_ext_q  <= EXTENTS_RESET;
			out_ext_q <= EXTENTS_RESET;
			win_q     <= WINDOWS_RESET;
			stride_q  <= STRIDES_RESET;
			pad_q     <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_POOL_MODE:   mode_q    <= cfg_data[0];
				REG_IN_EXTENTS:  in_ext_q  <= cfg_data[29:0];
				REG_OUT_EXTENTS: out_ext_q <= cfg_data[29:0];
				REG_WINDOWS:     win_q     <= cfg_data[8:0];
				REG_STRIDES:     stride_q  <= cfg_data[11:0];
				REG_PADS:        pad_q     <= cfg_data[5:0];
				default: ;
			endcase
		end
	end

	assign accept = sample_valid && !sample_stall;
	assign axis_start = accept;

	// The raster counters move on as soon as a sample is taken; the axis
	// units hold the coordinate they were started with.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
			dep_q <= '0;
		end else if (accept) begin
			if ((EB+1)'(col_q) + 1'b1 >= (EB+1)'(in_ext_q[EB-1:0])) begin
				col_q <= '0;
				if ((EB+1)'(row_q) + 1'b1 >= (EB+1)'(in_ext_q[2*EB-1:EB])) begin
					row_q <= '0;
					if ((EB+1)'(dep_q) + 1'b1 >= (EB+1)'(in_ext_q[3*EB-1:2*EB])) begin
						dep_q <= '0;
					end else begin
						dep_q <= dep_q + 1'b1;
					end
				end else begin
					row_q <= row_q + 1'b1;
				end
			end else begin
				col_q <= col_q + 1'b1;
			end
		end
	end

	// One axis unit per dimension; all three finish in the same cycle.
	p3d_axis u_axis_w (
		.clk(clk), .arst_n(arst_n), .start(axis_start), .coord(col_q),
		.in_ext(in_ext_q[EB-1:0]), .out_ext(out_ext_q[EB-1:0]),
		.win(win_q[2:0]), .stride(stride_q[3:0]), .pad(pad_q[1:0]),
		.busy(bw), .hit(hw_c)
	);
	p3d_axis u_axis_h (
		.clk(clk), .arst_n(arst_n), .start(axis_start), .coord(row_q),
		.in_ext(in_ext_q[2*EB-1:EB]), .out_ext(out_ext_q[2*EB-1:EB]),
		.win(win_q[5:3]), .stride(stride_q[7:4]), .pad(pad_q[3:2]),
		.busy(bh), .hit(hh_c)
	);
	p3d_axis u_axis_d (
		.clk(clk), .arst_n(arst_n), .start(axis_start), .coord(dep_q),
		.in_ext(in_ext_q[3*EB-1:2*EB]), .out_ext(out_ext_q[3*EB-1:2*EB]),
		.win(win_q[8:6]), .stride(stride_q[11:8]), .pad(pad_q[5:4]),
		.busy(bd), .hit(hd_c)
	);
	assign div_busy = bw || bh || bd;

	// Address of the current window, modulo the accumulator depth.
	assign addr = dterm_q + hterm_q + ADDR_BITS'(pw_q);

	p3d_accmem u_mem (
		.clk     (clk),
		.wr_en   (mem_wr),
		.wr_addr (addr),
		.wr_data (acc_new),
		.rd_en   (mem_rd),
		.rd_addr (addr),
		.rd_data (rd_data)
	);

	// Read-modify-write of one accumulator; the read of the next window is
	// never issued before this write has landed.
	assign acc_old   = $signed(rd_data);
	assign first_all = hd_q.first[jd_q] && hh_q.first[jh_q] && hw_q.first[jw_q];
	assign last_all  = hd_q.last[jd_q] && hh_q.last[jh_q] && hw_q.last[jw_q];

	always_comb begin
		if (mode_q == MODE_AVG) begin
			acc_new = first_all ? ACC_BITS'(smp_q) : acc_old + ACC_BITS'(smp_q);
		end else begin
			acc_new = (first_all || (ACC_BITS'(smp_q) > acc_old)) ?
				ACC_BITS'(smp_q) : acc_old;
		end
	end

	assign avg_cnt = COUNT_BITS'(hd_q.len[jd_q]) * COUNT_BITS'(hh_q.len[jh_q])
		* COUNT_BITS'(hw_q.len[jw_q]);
	assign avg_mag = acc_new[ACC_BITS-1] ? ACC_BITS'(-acc_new) : ACC_BITS'(acc_new);

	p3d_div #(.DW(ACC_BITS), .VW(COUNT_BITS), .STEP(4)) u_avg_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (avg_start),
		.dividend  (avg_mag),
		.divisor   (avg_cnt),
		.busy      (avg_busy),
		.quotient  (avg_quo),
		.remainder (avg_rem)
	);

	// Saturate the finished value to the sample range. The remainder of the
	// average divide is not needed; truncation toward zero comes from
	// dividing the magnitude.
	always_comb begin
		logic signed [ACC_BITS:0] v;
		if (mode_q == MODE_AVG) begin
			v = neg_q ? -$signed({1'b0, avg_quo}) : $signed({1'b0, avg_quo});
		end else begin
			v = (ACC_BITS+1)'(acc_q);
		end
		if (v > (ACC_BITS+1)'($signed({1'b0, {(SAMPLE_BITS-1){1'b1}}}))) begin
			res_value = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
		end else if (v < -$signed((ACC_BITS+1)'({1'b1, {(SAMPLE_BITS-1){1'b0}}}))) begin
			res_value = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
		end else begin
			res_value = SAMPLE_BITS'(v);
		end
	end

	assign adv_done = (jw_q == hw_q.jmin) && (jh_q == hh_q.jmin) && (jd_q == hd_q.jmin);

	// Next-state logic.
	always_comb begin
		state_n = state_q;
		case (state_q)
			ST_IDLE: if (accept) state_n = ST_DIV;
			ST_DIV:  if (!div_busy) state_n = ST_HITS;
			ST_HITS: state_n = (hw_c.any && hh_c.any && hd_c.any) ? ST_MUL1 : ST_IDLE;
			ST_MUL1: state_n = ST_MUL2;
			ST_MUL2: state_n = ST_RD;
			ST_RD:   state_n = ST_WR;
			ST_WR: begin
				if (!last_all) begin
					state_n = ST_ADV;
				end else if (mode_q == MODE_AVG) begin
					state_n = ST_AVG;
				end else begin
					state_n = ST_OUT;
				end
			end
			ST_AVG:  if (!avg_busy && !avg_start) state_n = ST_OUT;
			ST_OUT:  if (!result_valid || !result_stall) state_n = ST_ADV;
			ST_ADV:  state_n = adv_done ? ST_IDLE : ST_RD;
			default: state_n = ST_IDLE;
		endcase
	end

	// Output and strobe logic.
	always_comb begin
		sample_stall = (state_q != ST_IDLE);
		mem_rd       = (state_q == ST_RD);
		mem_wr       = (state_q == ST_WR);
		avg_start    = (state_q == ST_WR) && last_all && (mode_q == MODE_AVG);
		out_load     = (state_q == ST_OUT) && (!result_valid || !result_stall);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_n;
		end
	end

	// Window walk: depth outermost, width innermost, ascending output index.
	always_ff @(posedge clk) begin
		if (accept) begin
			smp_q <= sample;
		end
		case (state_q)
			ST_HITS: begin
				hw_q <= hw_c;
				hh_q <= hh_c;
				hd_q <= hd_c;
			end
			ST_MUL1: begin
				plane_q  <= ADDR_BITS'(out_ext_q[2*EB-1:EB] * out_ext_q[EB-1:0]);
				hterm0_q <= ADDR_BITS'(hh_q.plo * out_ext_q[EB-1:0]);
				jw_q     <= hw_q.jmax;
				jh_q     <= hh_q.jmax;
				jd_q     <= hd_q.jmax;
				pw_q     <= hw_q.plo;
			end
			ST_MUL2: begin
				dterm_q <= ADDR_BITS'(ADDR_BITS'(hd_q.plo) * plane_q);
				hterm_q <= hterm0_q;
			end
			ST_WR: begin
				acc_q <= acc_new;
				neg_q <= acc_new[ACC_BITS-1];
				lir_q <= (jw_q == hw_q.jl) && (jh_q == hh_q.jl) && (jd_q == hd_q.jl);
				lov_q <= hw_q.endpos[jw_q] && hh_q.endpos[jh_q] && hd_q.endpos[jd_q];
			end
			ST_ADV: begin
				if (jw_q != hw_q.jmin) begin
					jw_q <= jw_q - 1'b1;
					pw_q <= pw_q + 1'b1;
				end else begin
					jw_q <= hw_q.jmax;
					pw_q <= hw_q.plo;
					if (jh_q != hh_q.jmin) begin
						jh_q    <= jh_q - 1'b1;
						hterm_q <= hterm_q + ADDR_BITS'(out_ext_q[EB-1:0]);
					end else begin
						jh_q    <= hh_q.jmax;
						hterm_q <= hterm0_q;
						jd_q    <= jd_q - 1'b1;
						dterm_q <= dterm_q + plane_q;
					end
				end
			end
			default: ;
		endcase
	end

	// Output register: a finished item waits here while the walk goes on.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid <= 1'b0;
		end else if (out_load) begin
			result_valid <= 1'b1;
		end else if (!result_stall) begin
			result_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			pooled_value   <= res_value;
			out_position   <= addr;
			last_in_run    <= lir_q;
			last_of_volume <= lov_q;
		end
	end

endmodule

[tb/tb_pool3d_forward_max_avg.sv]
module tb_pool3d_forward_max_avg;
	import p3d_pkg::*;

	// One finished window as the block should report it.
	typedef struct {
		logic signed [SAMPLE_BITS-1:0] value;
		logic [ADDR_BITS-1:0]          position;
		logic                          run_end;
		logic                          volume_end;
	} pooled_window_t;

	typedef int quad_t[MAX_WINDOW];
	typedef bit quad_flag_t[MAX_WINDOW];

	logic clk;
	logic arst_n;
	logic sample_valid;
	logic sample_stall;
	logic signed [SAMPLE_BITS-1:0] sample;
	logic result_valid;
	logic result_stall;
	logic signed [SAMPLE_BITS-1:0] pooled_value;
	logic [ADDR_BITS-1:0] out_position;
	logic last_in_run;
	logic last_of_volume;
	logic cfg_valid;
	logic cfg_ready;
	logic [CFG_IDX_BITS-1:0] cfg_index;
	logic [CFG_DATA_BITS-1:0] cfg_data;

	pool3d_forward_max_avg dut (
		.clk(clk),
		.arst_n(arst_n),
		.sample_valid(sample_valid),
		.sample_stall(sample_stall),
		.sample(sample),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.pooled_value(pooled_value),
		.out_position(out_position),
		.last_in_run(last_in_run),
		.last_of_volume(last_of_volume),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	// The predictor keeps its own copy of the registers, the accumulator
	// memory and the raster counters.
	logic                          mode_q;
	logic [29:0]                   in_ext_q;
	logic [29:0]                   out_ext_q;
	logic [8:0]                    win_q;
	logic [11:0]                   stride_q;
	logic [5:0]                    pad_q;
	logic signed [ACC_BITS-1:0]    window_sums [OUT_POSITIONS];
	int                            col_pos, row_pos, dep_pos;

	pooled_window_t pending_windows[$];
	bit             failed;
	int             items_sent;
	int             send_gap_pct;
	int             recv_stall_pct;
	longint         cycle_count;

	localparam longint CYCLE_LIMIT = 1500000;

	// Free-running clock with an 8-unit period.
	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// Watchdog: a hung handshake ends the run as a failure.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycle_count);
			$display("** pool3d_forward_max_avg: FAILED **");
			$finish;
		end
	end

	// The receiver stalls at random at the rate chosen for the current phase.
	always @(posedge clk) begin
		result_stall <= (recv_stall_pct > 0) && ($urandom_range(99) < recv_stall_pct);
	end

	// Every accepted result is compared with the oldest expectation. The
	// outputs are read at the edge itself, so they still hold the values the
	// block presented during the cycle that just ended.
	always @(posedge clk) begin
		pooled_window_t want;
		if (arst_n && result_valid && !result_stall) begin
			if (pending_windows.size() == 0) begin
				$display("%0t: unexpected result value=%0d position=%0d", $time,
					pooled_value, out_position);
				failed = 1'b1;
			end else begin
				want = pending_windows.pop_front();
				if (want.value !== pooled_value) begin
					$display("%0t: pooled_value expected %0d got %0d", $time,
						want.value, pooled_value);
					failed = 1'b1;
				end
				if (want.position !== out_position) begin
					$display("%0t: out_position expected %0d got %0d", $time,
						want.position, out_position);
					failed = 1'b1;
				end
				if (want.run_end !== last_in_run) begin
					$display("%0t: last_in_run expected %0b got %0b", $time,
						want.run_end, last_in_run);
					failed = 1'b1;
				end
				if (want.volume_end !== last_of_volume) begin
					$display("%0t: last_of_volume expected %0b got %0b", $time,
						want.volume_end, last_of_volume);
					failed = 1'b1;
				end
			end
		end
	end

	// Lists the windows along one axis that cover coordinate x, with the
	// in-range length of each and whether x is its first or last sample.
	function automatic void covering_windows(input int x, input int k, input int s,
			input int pad, input int in_ext, input int out_ext, output int n,
			output quad_t pos, output quad_flag_t opens, output quad_flag_t closes,
			output quad_t span);
		int t, lo, hi, p, start_c, end_c;
		n = 0;
		for (int i = 0; i < MAX_WINDOW; i++) begin
			pos[i] = 0;
			opens[i] = 0;
			closes[i] = 0;
			span[i] = 0;
		end
		if (x >= in_ext || k <= 0 || out_ext <= 0)
			return;
		t = x + pad - k + 1;
		lo = (t <= 0) ? 0 : (t + s - 1) / s;
		hi = (x + pad) / s;
		if (hi > out_ext - 1)
			hi = out_ext - 1;
		for (p = lo; p <= hi && n < MAX_WINDOW; p++) begin
			start_c = p * s - pad;
			end_c = start_c + k;
			if (start_c < 0)
				start_c = 0;
			if (end_c > in_ext)
				end_c = in_ext;
			pos[n] = p;
			opens[n] = (x == start_c);
			closes[n] = (x == end_c - 1);
			span[n] = end_c - start_c;
			n++;
		end
	endfunction

	// Folds one sample into every covering window, queues the windows it
	// finishes in ascending output order, then steps the raster counters.
	task automatic fold_sample(input logic signed [SAMPLE_BITS-1:0] smp);
		int ie[3], oe[3], k[3], s[3], pd[3], coord[3], nh[3];
		quad_t hpos[3], hspan[3];
		quad_flag_t hopen[3], hclose[3];
		longint flat, avg;
		int addr, cnt, first_idx;
		logic signed [ACC_BITS-1:0] acc;
		pooled_window_t w;
		bit opens, any;
		for (int a = 0; a < 3; a++) begin
			ie[a] = in_ext_q[a*EXTENT_BITS +: EXTENT_BITS];
			oe[a] = out_ext_q[a*EXTENT_BITS +: EXTENT_BITS];
			k[a] = win_q[a*3 +: 3];
			if (k[a] > MAX_WINDOW)
				k[a] = MAX_WINDOW;
			s[a] = stride_q[a*4 +: 4];
			if (s[a] == 0)
				s[a] = 1;
			pd[a] = pad_q[a*2 +: 2];
		end
		coord[0] = col_pos;
		coord[1] = row_pos;
		coord[2] = dep_pos;
		for (int a = 0; a < 3; a++)
			covering_windows(coord[a], k[a], s[a], pd[a], ie[a], oe[a], nh[a], hpos[a],
				hopen[a], hclose[a], hspan[a]);
		first_idx = pending_windows.size();
		any = 0;
		for (int i = 0; i < nh[2]; i++) begin
			for (int j = 0; j < nh[1]; j++) begin
				for (int l = 0; l < nh[0]; l++) begin
					flat = longint'(hpos[2][i]) * oe[1] * oe[0] + longint'(hpos[1][j]) * oe[0]
						+ hpos[0][l];
					addr = int'(flat % OUT_POSITIONS);
					acc = window_sums[addr];
					opens = hopen[2][i] && hopen[1][j] && hopen[0][l];
					if (mode_q == MODE_AVG) begin
						acc = opens ? ACC_BITS'(smp) : acc + ACC_BITS'(smp);
					end else if (opens || smp > acc) begin
						acc = smp;
					end
					window_sums[addr] = acc;
					if (hclose[2][i] && hclose[1][j] && hclose[0][l]) begin
						avg = acc;
						if (mode_q == MODE_AVG) begin
							cnt = hspan[2][i] * hspan[1][j] * hspan[0][l];
							if (cnt < 1)
								cnt = 1;
							avg = avg / cnt;
						end
						if (avg > 32767)
							avg = 32767;
						if (avg < -32768)
							avg = -32768;
						w.value = SAMPLE_BITS'(avg);
						w.position = addr[ADDR_BITS-1:0];
						w.run_end = 1'b0;
						w.volume_end = (hpos[2][i] == oe[2] - 1) && (hpos[1][j] == oe[1] - 1)
							&& (hpos[0][l] == oe[0] - 1);
						pending_windows.push_back(w);
						any = 1;
					end
				end
			end
		end
		if (any)
			pending_windows[pending_windows.size() - 1].run_end = 1'b1;
		col_pos++;
		if (col_pos >= ie[0]) begin
			col_pos = 0;
			row_pos++;
			if (row_pos >= ie[1]) begin
				row_pos = 0;
				dep_pos++;
				if (dep_pos >= ie[2])
					dep_pos = 0;
			end
		end
	endtask

	// Presents one item and returns in the time step of its acceptance, with
	// valid still high so that a following item can go straight out.
	task automatic send_sample(input logic signed [SAMPLE_BITS-1:0] v);
		if (send_gap_pct > 0 && $urandom_range(99) < send_gap_pct) begin
			sample_valid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		sample_valid <= 1'b1;
		sample <= v;
		do @(posedge clk); while (sample_stall);
		fold_sample(v);
		items_sent++;
	endtask

	// Holds a register write until the block takes it; valid is left high.
	task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx, input logic [29:0] v);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= v;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			REG_POOL_MODE:   mode_q = v[0];
			REG_IN_EXTENTS:  in_ext_q = v;
			REG_OUT_EXTENTS: out_ext_q = v;
			REG_WINDOWS:     win_q = v[8:0];
			REG_STRIDES:     stride_q = v[11:0];
			REG_PADS:        pad_q = v[5:0];
			default: ;
		endcase
	endtask

	task automatic program_pool(input logic m, input logic [29:0] ie, input logic [29:0] oe,
			input logic [8:0] k, input logic [11:0] s, input logic [5:0] p);
		write_reg(REG_POOL_MODE, 30'(m));
		write_reg(REG_IN_EXTENTS, ie);
		write_reg(REG_OUT_EXTENTS, oe);
		write_reg(REG_WINDOWS, 30'(k));
		write_reg(REG_STRIDES, 30'(s));
		write_reg(REG_PADS, 30'(p));
		cfg_valid <= 1'b0;
	endtask

	// Waits until every expected window has come out, then gives a
	// sample that caused no window time to leave the pipeline before
	// a register write.
	task automatic drain_block();
		sample_valid <= 1'b0;
		while (pending_windows.size() != 0)
			@(posedge clk);
		repeat (700) @(posedge clk);
	endtask

	function automatic logic signed [SAMPLE_BITS-1:0] pick_sample();
		case ($urandom_range(7))
			0: return 16'sh7fff;
			1: return -16'sh8000;
			2: return 16'($urandom_range(0, 15)) - 16'sd8;
			default: return 16'($urandom);
		endcase
	endfunction

	// Sends whole volumes, so the raster counters are back at zero at the end.
	task automatic send_volumes(input int count);
		int n;
		n = in_ext_q[9:0] * in_ext_q[19:10] * in_ext_q[29:20];
		for (int v = 0; v < count; v++)
			for (int i = 0; i < n; i++)
				send_sample(pick_sample());
	endtask

	// Reset configuration: a 1x1x1 volume with 1x1x1 max windows passes each
	// sample straight through, which shows the sample extremes and bit patterns.
	task automatic test_reset_passthrough();
		send_sample(16'sh7fff);
		send_sample(-16'sh8000);
		send_sample(16'sh0000);
		send_sample(-16'sh0001);
		send_sample(16'sh5555);
		send_sample(-16'sh5556);
		drain_block();
	endtask

	// Average mode with every oversized setting: windows of 7 clamp to 4,
	// stride zero acts as one, and the largest padding leaves most windows
	// partly outside the volume, so the divisor counts in-range samples only.
	task automatic test_average_clamped();
		program_pool(MODE_AVG, {10'd2, 10'd2, 10'd2}, {10'd2, 10'd2, 10'd2},
			9'h1ff, 12'h000, 6'h3f);
		for (int i = 0; i < 8; i++)
			send_sample((i % 2) ? -16'sh8000 : 16'sh7ffd);
		drain_block();
	endtask

	// Max windows of one sample with stride one on a small cube: each sample
	// closes exactly one window.
	task automatic test_max_overlap();
		program_pool(MODE_MAX, {10'd2, 10'd2, 10'd2}, {10'd2, 10'd2, 10'd2},
			{3'd1, 3'd1, 3'd1}, {4'd1, 4'd1, 4'd1}, 6'h00);
		send_volumes(1);
		drain_block();
	endtask

	// Zero-sized windows cover nothing; the largest output extents show that
	// nothing comes out even so.
	task automatic test_empty_windows();
		program_pool(MODE_MAX, {10'd1, 10'd1, 10'd3}, 30'h3fffffff,
			9'h000, 12'hfff, 6'h00);
		send_volumes(1);
		drain_block();
	endtask

	function automatic int natural_windows(input int ie, input int k, input int s, input int p);
		return (ie - 1 + p) / s + 1;
	endfunction

	// Random settings, each followed by one to three whole volumes. The
	// idling pattern changes with the share of items already sent.
	task automatic test_random_volumes();
		logic [29:0] ie, oe;
		logic [8:0] k;
		logic [11:0] s;
		logic [5:0] p;
		int e, kk, ss, pp, keff;
		while (items_sent < 300) begin
			if (items_sent < 120) begin
				send_gap_pct = 17;
				recv_stall_pct = 80;
			end else if (items_sent < 230) begin
				send_gap_pct = 80;
				recv_stall_pct = 17;
			end else begin
				send_gap_pct = 0;
				recv_stall_pct = 0;
			end
			for (int a = 0; a < 3; a++) begin
				e = $urandom_range(1, 4);
				kk = ($urandom_range(9) == 0) ? $urandom_range(0, 7) : $urandom_range(1, 4);
				ss = ($urandom_range(7) == 0) ? $urandom_range(0, 15) : $urandom_range(1, 3);
				keff = (kk > MAX_WINDOW) ? MAX_WINDOW : kk;
				pp = (keff == 0) ? 0 : $urandom_range(0, (keff - 1 > 3) ? 3 : keff - 1);
				ie[a*10 +: 10] = 10'(e);
				case ($urandom_range(9))
					0: oe[a*10 +: 10] = 10'h3ff;
					1: oe[a*10 +: 10] = 10'($urandom_range(1, 2));
					default: oe[a*10 +: 10] = 10'(natural_windows(e, keff, (ss == 0) ? 1 : ss, pp));
				endcase
				k[a*3 +: 3] = 3'(kk);
				s[a*4 +: 4] = 4'(ss);
				p[a*2 +: 2] = 2'(pp);
			end
			program_pool(1'($urandom_range(1)), ie, oe, k, s, p);
			send_volumes($urandom_range(1, 3));
			drain_block();
		end
	endtask

	initial begin
		arst_n = 1'b0;
		sample_valid <= 1'b0;
		sample <= '0;
		result_stall <= 1'b0;
		cfg_valid <= 1'b0;
		cfg_index <= REG_POOL_MODE;
		cfg_data <= '0;
		failed = 0;
		items_sent = 0;
		send_gap_pct = 17;
		recv_stall_pct = 80;
		cycle_count = 0;
		// Predictor starts from the reset register values and zero counters.
		mode_q = MODE_MAX;
		in_ext_q = EXTENTS_RESET;
		out_ext_q = EXTENTS_RESET;
		win_q = WINDOWS_RESET;
		stride_q = STRIDES_RESET;
		pad_q = '0;
		col_pos = 0;
		row_pos = 0;
		dep_pos = 0;
		foreach (window_sums[i])
			window_sums[i] = '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_passthrough();
		test_average_clamped();
		test_max_overlap();
		test_empty_windows();
		test_random_volumes();

		if (!failed) begin
			$display("** pool3d_forward_max_avg: PASSED **");
		end else begin
			$display("** pool3d_forward_max_avg: FAILED **");
		end
		$finish;
	end

endmodule
